FILE: sv/sfr_pkg.sv
// Shared types and constants for the serial frame receiver.
// No dependencies; used by the parser, the top level and the bench.
package sfr_pkg;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_BAD     = 2'd2,
        KIND_REJECT  = 2'd3
    } sfr_kind_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] CFG_MAX_PAYLOAD = 2'd2;

    localparam int unsigned        FIELD_LEN_W       = 12;
    localparam logic [FIELD_LEN_W-1:0] MAX_PAYLOAD_RESET = 12'd1024;

    typedef struct packed {
        logic [7:0]             sync_first;
        logic [7:0]             sync_second;
        logic [FIELD_LEN_W-1:0] max_payload;
    } sfr_cfg_t;

    // One result request as it leaves the parser
    typedef struct packed {
        sfr_kind_t              kind;
        logic [7:0]             data_byte;
        logic [FIELD_LEN_W-1:0] byte_index;
        logic [15:0]            address;
        logic [15:0]            block_id;
        logic [15:0]            function_id;
        logic [7:0]             op_type;
        logic [FIELD_LEN_W-1:0] payload_length;
        logic                   frame_end;
    } sfr_result_t;

endpackage

FILE: sv/sfr_in_stage.sv
// Input register for received bytes.
// Depends on nothing; the advance signal comes from the top level.
module sfr_in_stage
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_ready,
    input  logic [7:0] rx_byte,
    input  logic       advance,
    output logic       stage_valid,
    output logic [7:0] stage_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // Free slot, or the held byte moves on this cycle
    assign rx_ready   = !valid_reg || advance;
    assign valid_next = (rx_valid && rx_ready) || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register, no reset
    always_ff @(posedge clk)
    begin
        if (rx_valid && rx_ready)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_byte  = byte_reg;

endmodule

FILE: sv/sfr_parser.sv
// Frame parser: phase sequencer, header registers, payload count and checksum.
// Depends on sfr_pkg for the configuration and result types.
module sfr_parser
#(
    parameter int unsigned LEN_BITS = 12
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  sfr_pkg::sfr_cfg_t     cfg,
    input  logic [7:0]            in_byte,
    input  logic                  advance,
    output logic                  res_valid,
    output sfr_pkg::sfr_result_t  res
);

    typedef enum logic [3:0] {
        PH_SYNC1   = 4'd0,
        PH_SYNC2   = 4'd1,
        PH_ADDR_LO = 4'd2,
        PH_ADDR_HI = 4'd3,
        PH_BLK_LO  = 4'd4,
        PH_BLK_HI  = 4'd5,
        PH_FUNC_LO = 4'd6,
        PH_FUNC_HI = 4'd7,
        PH_OP      = 4'd8,
        PH_LEN_LO  = 4'd9,
        PH_LEN_HI  = 4'd10,
        PH_PAYLOAD = 4'd11
    } phase_t;

    phase_t                            phase_reg,  phase_next;
    logic [LEN_BITS-1:0]               count_reg,  count_next;
    logic [7:0]                        hold_reg,   hold_next;
    logic [15:0]                       addr_reg,   addr_next;
    logic [15:0]                       block_reg,  block_next;
    logic [15:0]                       func_reg,   func_next;
    logic [7:0]                        op_reg,     op_next;
    logic [sfr_pkg::FIELD_LEN_W-1:0]   length_reg, length_next;
    logic [7:0]                        xor_reg,    xor_next;

    logic [15:0]                       len_word;
    logic                              len_bad;
    sfr_pkg::sfr_kind_t                kind_sel;
    logic                              end_sel;

    // Length word check: nibble inverse, configured limit, counter range
    assign len_word = {in_byte, hold_reg};
    assign len_bad  = (len_word[15:12] != ~len_word[3:0])
                   || (len_word[11:0] > cfg.max_payload)
                   || ((len_word[11:0] >> LEN_BITS) != 12'd0);

    // Next state and result for the byte in the input register
    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        hold_next   = hold_reg;
        addr_next   = addr_reg;
        block_next  = block_reg;
        func_next   = func_reg;
        op_next     = op_reg;
        length_next = length_reg;
        xor_next    = xor_reg;
        res_valid   = 1'b0;
        kind_sel    = sfr_pkg::KIND_PAYLOAD;
        end_sel     = 1'b0;
        unique case (phase_reg)
            PH_SYNC1:
            begin
                if (in_byte == cfg.sync_first)
                begin
                    phase_next = PH_SYNC2;
                end
            end
            PH_SYNC2:
            begin
                // second marker wins when both markers are equal
                if (in_byte == cfg.sync_second)
                begin
                    phase_next = PH_ADDR_LO;
                end
                else if (in_byte != cfg.sync_first)
                begin
                    phase_next = PH_SYNC1;
                end
            end
            PH_ADDR_LO:
            begin
                hold_next  = in_byte;
                xor_next   = in_byte;
                phase_next = PH_ADDR_HI;
            end
            PH_ADDR_HI:
            begin
                addr_next  = {in_byte, hold_reg};
                xor_next   = xor_reg ^ in_byte;
                phase_next = PH_BLK_LO;
            end
            PH_BLK_LO:
            begin
                hold_next  = in_byte;
                xor_next   = xor_reg ^ in_byte;
                phase_next = PH_BLK_HI;
            end
            PH_BLK_HI:
            begin
                block_next = {in_byte, hold_reg};
                xor_next   = xor_reg ^ in_byte;
                phase_next = PH_FUNC_LO;
            end
            PH_FUNC_LO:
            begin
                hold_next  = in_byte;
                xor_next   = xor_reg ^ in_byte;
                phase_next = PH_FUNC_HI;
            end
            PH_FUNC_HI:
            begin
                func_next  = {in_byte, hold_reg};
                xor_next   = xor_reg ^ in_byte;
                phase_next = PH_OP;
            end
            PH_OP:
            begin
                op_next    = in_byte;
                xor_next   = xor_reg ^ in_byte;
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                hold_next  = in_byte;
                xor_next   = xor_reg ^ in_byte;
                phase_next = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                length_next = len_word[11:0];
                xor_next    = xor_reg ^ in_byte;
                count_next  = '0;
                if (len_bad)
                begin
                    phase_next = PH_SYNC1;
                    res_valid  = 1'b1;
                    kind_sel   = sfr_pkg::KIND_REJECT;
                    end_sel    = 1'b1;
                end
                else
                begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                res_valid = 1'b1;
                if (12'(count_reg) < length_reg)
                begin
                    xor_next   = xor_reg ^ in_byte;
                    count_next = count_reg + 1'b1;
                end
                else
                begin
                    // check byte closes the frame
                    phase_next = PH_SYNC1;
                    count_next = '0;
                    kind_sel   = (in_byte == xor_reg) ? sfr_pkg::KIND_GOOD
                                                      : sfr_pkg::KIND_BAD;
                    end_sel    = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_SYNC1;
                count_next = '0;
            end
        endcase
    end

    // Result request, headers taken after this byte's update
    always_comb
    begin
        res.kind           = kind_sel;
        res.data_byte      = (kind_sel == sfr_pkg::KIND_PAYLOAD) ? in_byte : 8'd0;
        res.byte_index     = (kind_sel == sfr_pkg::KIND_PAYLOAD) ? 12'(count_reg) : 12'd0;
        res.address        = addr_next;
        res.block_id       = block_next;
        res.function_id    = func_next;
        res.op_type        = op_next;
        res.payload_length = length_next;
        res.frame_end      = end_sel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SYNC1;
            count_reg  <= '0;
            hold_reg   <= '0;
            addr_reg   <= '0;
            block_reg  <= '0;
            func_reg   <= '0;
            op_reg     <= '0;
            length_reg <= '0;
            xor_reg    <= '0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            hold_reg   <= hold_next;
            addr_reg   <= addr_next;
            block_reg  <= block_next;
            func_reg   <= func_next;
            op_reg     <= op_next;
            length_reg <= length_next;
            xor_reg    <= xor_next;
        end
    end

    // Payload count never passes the length of an open frame
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> 12'(count_reg) <= length_reg)
        else $error("payload count beyond frame length");

    // A rejected length always restarts the hunt
    a_reject_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res_valid && res.kind == sfr_pkg::KIND_REJECT |=> phase_reg == PH_SYNC1)
        else $error("reject did not restart the hunt");

    // Only the payload phase and the length word give results
    a_res_phase: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (phase_reg == PH_PAYLOAD || phase_reg == PH_LEN_HI))
        else $error("result outside payload or length phase");

endmodule

FILE: sv/serial_frame_receiver.sv
// Serial frame receiver: config registers, input stage, parser, result register.
// Depends on sfr_pkg, sfr_in_stage and sfr_parser.
// An accepted byte is held in the input register; its result is registered in the output register.
// Throughput: one byte per cycle; the input register takes a byte while a
// result waits in the output register, and stalls only when both are full.
// Reset (rst_n low, asynchronous): hunt for first marker, markers 0, max 1024.
module serial_frame_receiver
#(
    parameter int unsigned LEN_BITS = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_wdata,
    input  logic        rx_valid,
    output logic        rx_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  data_byte,
    output logic [11:0] byte_index,
    output logic [15:0] address,
    output logic [15:0] block_id,
    output logic [15:0] function_id,
    output logic [7:0]  op_type,
    output logic [11:0] payload_length,
    output logic        frame_end
);

    sfr_pkg::sfr_cfg_t    cfg_reg;
    logic                 stage_valid;
    logic [7:0]           stage_byte;
    logic                 advance;
    logic                 res_valid;
    sfr_pkg::sfr_result_t res;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    sfr_pkg::sfr_result_t out_reg;

    // Configuration writes; unused index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_first  <= 8'd0;
            cfg_reg.sync_second <= 8'd0;
            cfg_reg.max_payload <= sfr_pkg::MAX_PAYLOAD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sfr_pkg::CFG_SYNC_FIRST:  cfg_reg.sync_first  <= cfg_wdata[7:0];
                sfr_pkg::CFG_SYNC_SECOND: cfg_reg.sync_second <= cfg_wdata[7:0];
                sfr_pkg::CFG_MAX_PAYLOAD: cfg_reg.max_payload <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // Byte moves through the parser when the result slot is free or draining
    assign advance = stage_valid && (!out_valid_reg || out_ready);

    sfr_in_stage u_in_stage
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_valid    (rx_valid),
        .rx_ready    (rx_ready),
        .rx_byte     (rx_byte),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_byte  (stage_byte)
    );

    sfr_parser #(
        .LEN_BITS (LEN_BITS)
    ) u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_byte   (stage_byte),
        .advance   (advance),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register
    assign out_valid_next = advance ? res_valid : (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = out_reg.kind;
    assign data_byte      = out_reg.data_byte;
    assign byte_index     = out_reg.byte_index;
    assign address        = out_reg.address;
    assign block_id       = out_reg.block_id;
    assign function_id    = out_reg.function_id;
    assign op_type        = out_reg.op_type;
    assign payload_length = out_reg.payload_length;
    assign frame_end      = out_reg.frame_end;

    // A waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !advance)
        else $error("result register overwritten while waiting");

    // frame_end marks exactly the closing kinds
    a_end_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.frame_end == (out_reg.kind != sfr_pkg::KIND_PAYLOAD)))
        else $error("frame_end does not match result kind");

    // Payload bytes stay inside the announced length
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.kind == sfr_pkg::KIND_PAYLOAD
            |-> out_reg.byte_index < out_reg.payload_length)
        else $error("payload index beyond length");

endmodule

FILE: bench/serial_frame_receiver_checker.sv
// Checker for the serial frame receiver: mirrors the config registers,
// predicts every result request from the accepted bytes and compares them.
// Depends on sfr_pkg; instantiated beside the block by serial_frame_receiver_tb.
module serial_frame_receiver_checker
#(
    parameter int unsigned LEN_BITS = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_wdata,
    input  logic        rx_valid,
    input  logic        rx_ready,
    input  logic [7:0]  rx_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  kind,
    input  logic [7:0]  data_byte,
    input  logic [11:0] byte_index,
    input  logic [15:0] address,
    input  logic [15:0] block_id,
    input  logic [15:0] function_id,
    input  logic [7:0]  op_type,
    input  logic [11:0] payload_length,
    input  logic        frame_end,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Parser phases
    localparam logic [3:0] PH_HUNT    = 4'd0;
    localparam logic [3:0] PH_SYNC2   = 4'd1;
    localparam logic [3:0] PH_ADDR_LO = 4'd2;
    localparam logic [3:0] PH_ADDR_HI = 4'd3;
    localparam logic [3:0] PH_BLK_LO  = 4'd4;
    localparam logic [3:0] PH_BLK_HI  = 4'd5;
    localparam logic [3:0] PH_FUNC_LO = 4'd6;
    localparam logic [3:0] PH_FUNC_HI = 4'd7;
    localparam logic [3:0] PH_OP      = 4'd8;
    localparam logic [3:0] PH_LEN_LO  = 4'd9;
    localparam logic [3:0] PH_LEN_HI  = 4'd10;
    localparam logic [3:0] PH_PAYLOAD = 4'd11;

    localparam int unsigned LEN_LIMIT    = (1 << LEN_BITS) - 1;
    localparam int          PRINT_LIMIT  = 40;

    sfr_pkg::sfr_cfg_t cfg_shadow;
    logic [3:0]  phase;
    logic [11:0] pay_count;
    logic [7:0]  low_hold;
    logic [15:0] addr_r;
    logic [15:0] blk_r;
    logic [15:0] func_r;
    logic [7:0]  op_r;
    logic [11:0] len_r;
    logic [7:0]  xor_acc;

    // Expected result requests, oldest first
    sfr_pkg::sfr_result_t frame_results_q[$];

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    task automatic report_mismatch(input string msg);
        begin
            errors++;
            if (errors <= PRINT_LIMIT)
                $display("%0t ns  frame check: %s", $time, msg);
        end
    endtask

    task automatic cmp_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
        begin
            if (got !== want)
                report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
        end
    endtask

    // Queue a result carrying the current header fields
    task automatic push_result(input sfr_pkg::sfr_kind_t k, input logic [7:0] d,
                               input logic [11:0] idx, input logic last);
        sfr_pkg::sfr_result_t r;
        begin
            r.kind           = k;
            r.data_byte      = d;
            r.byte_index     = idx;
            r.address        = addr_r;
            r.block_id       = blk_r;
            r.function_id    = func_r;
            r.op_type        = op_r;
            r.payload_length = len_r;
            r.frame_end      = last;
            frame_results_q.push_back(r);
        end
    endtask

    // Advance the frame parser by one received byte
    task automatic parse_byte(input logic [7:0] b);
        logic [15:0] word;
        logic        nib_ok;
        begin
            case (phase)
                PH_HUNT:
                begin
                    if (b == cfg_shadow.sync_first)
                        phase = PH_SYNC2;
                end
                PH_SYNC2:
                begin
                    // second marker wins when both markers are equal
                    if (b == cfg_shadow.sync_second)
                        phase = PH_ADDR_LO;
                    else if (b != cfg_shadow.sync_first)
                        phase = PH_HUNT;
                end
                PH_ADDR_LO:
                begin
                    low_hold = b;
                    xor_acc  = b;
                    phase    = PH_ADDR_HI;
                end
                PH_ADDR_HI:
                begin
                    addr_r  = {b, low_hold};
                    xor_acc = xor_acc ^ b;
                    phase   = PH_BLK_LO;
                end
                PH_BLK_LO, PH_FUNC_LO, PH_LEN_LO:
                begin
                    low_hold = b;
                    xor_acc  = xor_acc ^ b;
                    phase    = phase + 4'd1;
                end
                PH_BLK_HI:
                begin
                    blk_r   = {b, low_hold};
                    xor_acc = xor_acc ^ b;
                    phase   = PH_FUNC_LO;
                end
                PH_FUNC_HI:
                begin
                    func_r  = {b, low_hold};
                    xor_acc = xor_acc ^ b;
                    phase   = PH_OP;
                end
                PH_OP:
                begin
                    op_r    = b;
                    xor_acc = xor_acc ^ b;
                    phase   = PH_LEN_LO;
                end
                PH_LEN_HI:
                begin
                    word      = {b, low_hold};
                    xor_acc   = xor_acc ^ b;
                    len_r     = word[11:0];
                    pay_count = '0;
                    nib_ok    = (word[15:12] == ~word[3:0]);
                    if (!nib_ok || len_r > cfg_shadow.max_payload ||
                        32'(len_r) > LEN_LIMIT)
                    begin
                        phase = PH_HUNT;
                        push_result(sfr_pkg::KIND_REJECT, 8'd0, 12'd0, 1'b1);
                    end
                    else
                        phase = PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    if (pay_count < len_r)
                    begin
                        push_result(sfr_pkg::KIND_PAYLOAD, b, pay_count, 1'b0);
                        xor_acc   = xor_acc ^ b;
                        pay_count = pay_count + 12'd1;
                    end
                    else
                    begin
                        // check byte closes the frame
                        phase     = PH_HUNT;
                        pay_count = '0;
                        push_result((b == xor_acc) ? sfr_pkg::KIND_GOOD : sfr_pkg::KIND_BAD,
                                    8'd0, 12'd0, 1'b1);
                    end
                end
                default:
                begin
                    phase     = PH_HUNT;
                    pay_count = '0;
                end
            endcase
        end
    endtask

    // Compare one accepted result request with the oldest expectation
    task automatic check_result();
        sfr_pkg::sfr_result_t want;
        begin
            if (frame_results_q.size() == 0)
                report_mismatch($sformatf("result kind %0d with nothing expected", kind));
            else
            begin
                want = frame_results_q.pop_front();
                cmp_field("kind",           16'(kind),           16'(want.kind));
                cmp_field("data_byte",      16'(data_byte),      16'(want.data_byte));
                cmp_field("byte_index",     16'(byte_index),     16'(want.byte_index));
                cmp_field("address",        address,             want.address);
                cmp_field("block_id",       block_id,            want.block_id);
                cmp_field("function_id",    function_id,         want.function_id);
                cmp_field("op_type",        16'(op_type),        16'(want.op_type));
                cmp_field("payload_length", 16'(payload_length), 16'(want.payload_length));
                cmp_field("frame_end",      16'(frame_end),      16'(want.frame_end));
            end
        end
    endtask

    // Watch the ports at every rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_shadow.sync_first  = 8'd0;
            cfg_shadow.sync_second = 8'd0;
            cfg_shadow.max_payload = sfr_pkg::MAX_PAYLOAD_RESET;
            phase     = PH_HUNT;
            pay_count = '0;
            low_hold  = '0;
            addr_r    = '0;
            blk_r     = '0;
            func_r    = '0;
            op_r      = '0;
            len_r     = '0;
            xor_acc   = '0;
            frame_results_q.delete();
            pending   = 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_result();
            if (cfg_we)
            begin
                case (cfg_index)
                    sfr_pkg::CFG_SYNC_FIRST:  cfg_shadow.sync_first  = cfg_wdata[7:0];
                    sfr_pkg::CFG_SYNC_SECOND: cfg_shadow.sync_second = cfg_wdata[7:0];
                    sfr_pkg::CFG_MAX_PAYLOAD: cfg_shadow.max_payload = cfg_wdata;
                    default: ;
                endcase
            end
            if (rx_valid && rx_ready)
                parse_byte(rx_byte);
            pending = frame_results_q.size();
        end
    end

endmodule

FILE: bench/serial_frame_receiver_tb.sv
// Testbench top for the serial frame receiver: clock, reset, config writes,
// byte and result stimulus with idling and back-pressure, and the verdict.
// Depends on sfr_pkg, serial_frame_receiver and serial_frame_receiver_checker.
module serial_frame_receiver_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET  = 1050;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 8;

    // Check byte choices for a frame
    localparam logic [1:0] CHK_GOOD   = 2'd0;
    localparam logic [1:0] CHK_BAD    = 2'd1;
    localparam logic [1:0] CHK_MARKER = 2'd2;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [11:0] cfg_wdata;
    logic        rx_valid;
    logic        rx_ready;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [11:0] byte_index;
    logic [15:0] address;
    logic [15:0] block_id;
    logic [15:0] function_id;
    logic [7:0]  op_type;
    logic [11:0] payload_length;
    logic        frame_end;

    int          errors;
    int          pending;
    int          bytes_sent;
    bit          idle_en;
    bit          hold_req;
    logic [7:0]  sync1_now;
    logic [7:0]  sync2_now;
    logic [11:0] max_now;

    serial_frame_receiver i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .rx_valid       (rx_valid),
        .rx_ready       (rx_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .data_byte      (data_byte),
        .byte_index     (byte_index),
        .address        (address),
        .block_id       (block_id),
        .function_id    (function_id),
        .op_type        (op_type),
        .payload_length (payload_length),
        .frame_end      (frame_end)
    );

    serial_frame_receiver_checker i_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .rx_valid       (rx_valid),
        .rx_ready       (rx_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .data_byte      (data_byte),
        .byte_index     (byte_index),
        .address        (address),
        .block_id       (block_id),
        .function_id    (function_id),
        .op_type        (op_type),
        .payload_length (payload_length),
        .frame_end      (frame_end),
        .errors         (errors),
        .pending        (pending)
    );

    // 100 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop
    initial
    begin
        #2_000_000;
        $display("serial_frame_receiver: mismatch");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            out_ready = !(idle_en && $urandom_range(0, 99) < 7);
        end
    end

    // Length word with a matching check nibble
    function automatic logic [15:0] good_len_word(input logic [11:0] len);
        return {~len[3:0], len};
    endfunction

    // Offer one byte request and wait until it is taken
    task automatic send_byte(input logic [7:0] value);
        int gap;
        begin
            @(negedge clk);
            gap = (idle_en && $urandom_range(0, 99) < 7) ? $urandom_range(1, 5) : 0;
            if (gap > 0)
            begin
                rx_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            rx_valid = 1'b1;
            rx_byte  = value;
            do
                @(posedge clk);
            while (!rx_ready);
            bytes_sent++;
        end
    endtask

    // Stop offering bytes and let every pending result drain
    task automatic wait_idle();
        begin
            @(negedge clk);
            rx_valid = 1'b0;
            do
                @(negedge clk);
            while (pending != 0);
            repeat (DRAIN_CYCLES) @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [11:0] value);
        begin
            @(negedge clk);
            cfg_we    = 1'b1;
            cfg_index = idx;
            cfg_wdata = value;
            @(negedge clk);
            cfg_we    = 1'b0;
        end
    endtask

    task automatic set_config(input logic [7:0] s1, input logic [7:0] s2,
                              input logic [11:0] mx);
        begin
            wait_idle();
            write_reg(sfr_pkg::CFG_SYNC_FIRST, {4'd0, s1});
            write_reg(sfr_pkg::CFG_SYNC_SECOND, {4'd0, s2});
            write_reg(sfr_pkg::CFG_MAX_PAYLOAD, mx);
            sync1_now = s1;
            sync2_now = s2;
            max_now   = mx;
        end
    endtask

    // Markers, header, then payload and check byte if the length is accepted
    task automatic send_frame(input logic [15:0] addr, input logic [15:0] blk,
                              input logic [15:0] func, input logic [7:0] op,
                              input logic [15:0] len_word, input logic [1:0] chk_mode,
                              input int lead_syncs);
        logic [7:0] hdr [9];
        logic [7:0] chk;
        logic [7:0] pb;
        int         i;
        begin
            hdr = '{addr[7:0], addr[15:8], blk[7:0], blk[15:8], func[7:0],
                    func[15:8], op, len_word[7:0], len_word[15:8]};
            chk = 8'd0;
            repeat (lead_syncs) send_byte(sync1_now);
            send_byte(sync1_now);
            send_byte(sync2_now);
            for (i = 0; i < 9; i++)
            begin
                send_byte(hdr[i]);
                chk = chk ^ hdr[i];
            end
            if (len_word[15:12] == ~len_word[3:0] && len_word[11:0] <= max_now)
            begin
                for (i = 0; i < int'(len_word[11:0]); i++)
                begin
                    pb = 8'($urandom);
                    send_byte(pb);
                    chk = chk ^ pb;
                end
                case (chk_mode)
                    CHK_GOOD: send_byte(chk);
                    CHK_BAD:  send_byte(chk ^ 8'($urandom_range(1, 255)));
                    default:  send_byte(sync1_now);
                endcase
            end
        end
    endtask

    // Main stimulus
    initial
    begin
        int          r;
        int          n;
        int          frames_left;
        int          lim;
        int          lead;
        logic [11:0] len;
        logic [15:0] word;
        logic [7:0]  s1;
        logic [7:0]  s2;
        logic [11:0] mx;
        logic [1:0]  mode;

        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = sfr_pkg::CFG_SYNC_FIRST;
        cfg_wdata  = 12'd0;
        rx_valid   = 1'b0;
        rx_byte    = 8'd0;
        idle_en    = 1'b1;
        hold_req   = 1'b0;
        bytes_sent = 0;
        sync1_now  = 8'd0;
        sync2_now  = 8'd0;
        max_now    = sfr_pkg::MAX_PAYLOAD_RESET;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: equal zero markers, lengths of zero, over the reset limit and two
        send_frame(16'h0000, 16'h0000, 16'h0000, 8'h00, good_len_word(12'd0), CHK_GOOD, 0);
        send_frame(16'h1234, 16'h5678, 16'h9abc, 8'h5a, good_len_word(12'd1025),
                   CHK_GOOD, 0);
        send_frame(16'h8001, 16'h0180, 16'h7ffe, 8'h80, good_len_word(12'd2), CHK_GOOD, 0);

        // Distinct markers, widest limit
        set_config(8'haa, 8'h55, 12'd4095);
        send_frame(16'hffff, 16'hffff, 16'hffff, 8'hff, good_len_word(12'd3), CHK_BAD, 2);
        send_frame(16'h00ff, 16'hff00, 16'h0f0f, 8'h01, good_len_word(12'd4095) ^ 16'h1000,
                   CHK_GOOD, 0);

        // Long payload while the result side holds off
        hold_req = 1'b1;
        send_frame(16'h4242, 16'h0001, 16'h0002, 8'h03, good_len_word(12'd40), CHK_GOOD, 0);

        // Rejecting byte and check byte equal to the first marker
        send_frame(16'h0101, 16'h0202, 16'h0303, 8'h04, 16'haa00, CHK_GOOD, 0);
        send_byte(8'h55);
        send_frame(16'h1111, 16'h2222, 16'h3333, 8'h44, good_len_word(12'd1), CHK_MARKER, 0);
        send_byte(8'h55);
        send_frame(16'hbeef, 16'hcafe, 16'h0bad, 8'h7f, good_len_word(12'd2), CHK_GOOD, 1);

        // Equal markers, zero limit
        set_config(8'h3c, 8'h3c, 12'd0);
        send_frame(16'h0000, 16'hffff, 16'h0000, 8'hff, good_len_word(12'd0), CHK_GOOD, 0);
        send_frame(16'hffff, 16'h0000, 16'hffff, 8'h00, good_len_word(12'd1), CHK_GOOD, 0);
        send_frame(16'h5a5a, 16'ha5a5, 16'h5a5a, 8'ha5, good_len_word(12'd0), CHK_BAD, 0);
        for (n = 0; n < 4; n++)
            send_byte(8'($urandom));

        // Random frames, noise and broken headers under changing settings
        frames_left = 0;
        while (bytes_sent < ITEM_TARGET)
        begin
            if (frames_left == 0)
            begin
                s1 = 8'($urandom);
                s2 = ($urandom_range(0, 99) < 10) ? s1 : 8'($urandom);
                case ($urandom_range(0, 3))
                    0:       mx = 12'd0;
                    1:       mx = 12'd4095;
                    2:       mx = 12'($urandom_range(1, 30));
                    default: mx = 12'($urandom_range(0, 4095));
                endcase
                set_config(s1, s2, mx);
                frames_left = $urandom_range(4, 10);
            end
            frames_left--;
            idle_en = (bytes_sent < 350 || bytes_sent >= 600);

            r = $urandom_range(0, 99);
            if (r < 5)
            begin
                // line noise
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            end
            else if (r < 9)
            begin
                // header cut short, the next frame runs into it
                send_byte(sync1_now);
                send_byte(sync2_now);
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            end
            else
            begin
                lim = (max_now < 24) ? int'(max_now) : 24;
                len = 12'($urandom_range(0, lim));
                r   = $urandom_range(0, 99);
                if (r < 5 && max_now > 80)
                    len = 12'($urandom_range(25, 80));
                else if (r < 10 && max_now < 12'd4095)
                    len = max_now + 12'd1;
                word = good_len_word(len);
                if ($urandom_range(0, 99) < 8)
                    word[15:12] = word[15:12] ^ 4'($urandom_range(1, 15));
                r = $urandom_range(0, 99);
                mode = (r < 80) ? CHK_GOOD : (r < 95) ? CHK_BAD : CHK_MARKER;
                lead = (sync1_now != sync2_now && $urandom_range(0, 99) < 10) ?
                       $urandom_range(1, 2) : 0;
                send_frame(16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                           word, mode, lead);
            end
        end

        // Drain and decide
        wait_idle();
        if (errors == 0)
            $display("serial_frame_receiver: match");
        else
            $display("serial_frame_receiver: mismatch");
        $finish;
    end

endmodule
